// ----- rtl/tlp_pkg.sv -----
// tlp_pkg: shared types and constants for the tag line parser
// no dependencies; imported by every rtl module of the block

package tlp_pkg;

    // parser phase within a line
    typedef enum logic [2:0] {
        PH_LINE   = 3'd0,
        PH_NAME   = 3'd1,
        PH_EQ     = 3'd2,
        PH_INT    = 3'd3,
        PH_STR    = 3'd4,
        PH_ESC    = 3'd5,
        PH_CLOSED = 3'd6,
        PH_ERR    = 3'd7
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_VAL  = 2'd1;
    localparam logic [1:0] KIND_REC  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // record status codes
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_ERROR = 3'd4;

    // characters the parser reacts to
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_NL     = 8'h0a;

    // result queue sizing
    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } result_t;

    // everything one input beat produces
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] count;
        phase_t     phase_next;
        logic       protect_next;
        logic       brace_next;
    } step_t;

endpackage

// ----- rtl/tlp_step.sv -----
// tlp_step: combinational parse step for one input beat
// depends on tlp_pkg for phase, result and step types

module tlp_step
    import tlp_pkg::*;
(
    input  phase_t     phase,
    input  logic       protect,
    input  logic       brace,
    input  logic [7:0] data_byte,
    input  logic       is_end,
    output step_t      step
);

    logic [7:0] closer;

    assign closer = brace ? CH_RBRACE : CH_RPAREN;

    always_comb begin
        step              = '0;
        step.phase_next   = phase;
        step.protect_next = protect;
        step.brace_next   = brace;

        if (is_end) begin
            if (phase == PH_LINE) begin
                step.res0.kind = KIND_END;
                step.count     = 2'd1;
            end else begin
                step.res0.kind    = KIND_REC;
                step.res0.status  = ST_ERROR;
                step.count        = 2'd1;
                step.phase_next   = PH_ERR;
                step.protect_next = 1'b0;
                step.brace_next   = 1'b0;
            end
        end else begin
            case (phase)
                PH_LINE, PH_NAME: begin
                    if (phase == PH_LINE && data_byte == CH_STAR) begin
                        step.protect_next = 1'b1;
                        step.phase_next   = PH_NAME;
                    end else if (data_byte == CH_NL) begin
                        step.res0.kind    = KIND_REC;
                        step.res0.status  = ST_ERROR;
                        step.count        = 2'd1;
                        step.phase_next   = PH_ERR;
                        step.protect_next = 1'b0;
                        step.brace_next   = 1'b0;
                    end else if (data_byte == CH_EQ) begin
                        step.phase_next = PH_EQ;
                    end else begin
                        step.res0.kind     = KIND_NAME;
                        step.res0.out_byte = data_byte;
                        step.count         = 2'd1;
                        step.phase_next    = PH_NAME;
                    end
                end
                PH_EQ: begin
                    if (data_byte == CH_LPAREN) begin
                        step.brace_next = 1'b0;
                        step.phase_next = PH_STR;
                    end else if (data_byte == CH_LBRACE) begin
                        step.brace_next = 1'b1;
                        step.phase_next = PH_STR;
                    end else if (data_byte == CH_NL) begin
                        step.res0.kind    = KIND_REC;
                        step.res0.status  = {1'b0, protect, 1'b1};
                        step.count        = 2'd1;
                        step.phase_next   = PH_LINE;
                        step.protect_next = 1'b0;
                        step.brace_next   = 1'b0;
                    end else begin
                        step.res0.kind     = KIND_VAL;
                        step.res0.out_byte = data_byte;
                        step.count         = 2'd1;
                        step.phase_next    = PH_INT;
                    end
                end
                PH_INT: begin
                    if (data_byte == CH_NL) begin
                        step.res0.kind    = KIND_REC;
                        step.res0.status  = {1'b0, protect, 1'b1};
                        step.count        = 2'd1;
                        step.phase_next   = PH_LINE;
                        step.protect_next = 1'b0;
                        step.brace_next   = 1'b0;
                    end else begin
                        step.res0.kind     = KIND_VAL;
                        step.res0.out_byte = data_byte;
                        step.count         = 2'd1;
                    end
                end
                PH_STR: begin
                    if (data_byte == CH_BSLASH) begin
                        step.phase_next = PH_ESC;
                    end else if (data_byte == closer) begin
                        step.phase_next = PH_CLOSED;
                    end else begin
                        step.res0.kind     = KIND_VAL;
                        step.res0.out_byte = data_byte;
                        step.count         = 2'd1;
                    end
                end
                PH_ESC: begin
                    step.phase_next = PH_STR;
                    step.res0.kind  = KIND_VAL;
                    if (data_byte == CH_N) begin
                        step.res0.out_byte = CH_NL;
                        step.count         = 2'd1;
                    end else if (data_byte inside {CH_LPAREN, CH_RPAREN, CH_BSLASH}) begin
                        step.res0.out_byte = data_byte;
                        step.count         = 2'd1;
                    end else begin
                        // unknown escape passes both bytes
                        step.res0.out_byte = CH_BSLASH;
                        step.res1.kind     = KIND_VAL;
                        step.res1.out_byte = data_byte;
                        step.count         = 2'd2;
                    end
                end
                PH_CLOSED: begin
                    step.res0.kind    = KIND_REC;
                    step.count        = 2'd1;
                    step.protect_next = 1'b0;
                    step.brace_next   = 1'b0;
                    if (data_byte == CH_NL) begin
                        step.res0.status = {1'b0, protect, 1'b0};
                        step.phase_next  = PH_LINE;
                    end else begin
                        step.res0.status = ST_ERROR;
                        step.phase_next  = PH_ERR;
                    end
                end
                default: begin
                    // error phase swallows data bytes
                end
            endcase
        end

        step.res0.last = (step.count == 2'd1);
        step.res1.last = (step.count == 2'd2);
    end

endmodule

// ----- rtl/tlp_out_fifo.sv -----
// tlp_out_fifo: small result queue, takes up to two results a cycle, gives one
// depends on tlp_pkg for result_t and queue sizing

module tlp_out_fifo
    import tlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   head_reg, head_next;
    logic [FIFO_AW-1:0]   tail_reg, tail_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[head_reg];
    assign pop       = out_valid && out_ready;
    // room for the largest burst one beat can produce
    assign room      = count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RESULTS);

    always_comb begin
        head_next  = pop ? head_reg + FIFO_AW'(1) : head_reg;
        tail_next  = tail_reg + FIFO_AW'(push_n);
        count_next = count_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[tail_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[tail_reg + FIFO_AW'(1)] <= push1;
        end
    end

endmodule

// ----- rtl/tag_line_parser.sv -----
// tag_line_parser: top level, input register, line state and result queue
// depends on tlp_pkg, tlp_step and tlp_out_fifo

// The parser takes one beat per cycle while the result queue has room, a data
// byte or an end-of-data marker, and turns tag lines of the form [*]name=value
// into a stream of result beats: name bytes, value bytes, one record beat per
// line with its type or an error, and an end beat for end of data at a line
// start. Input beats land in a one-entry input register; the parse step then
// runs on the registered beat once the queue has room and writes zero, one or
// two results into a four-entry result queue that drives the m_ channel. The
// sustained rate is one input beat per cycle while the queue has room, as the
// parse step is combinational; an unknown escape yields two result beats, and
// the queue absorbs the extra one. Results pass the input register, then the queue.
// An error is sticky: after it data bytes give nothing and each end of data
// gives another error record, until reset.

module tag_line_parser
    import tlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_is_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_status,
    output logic       m_last
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // line state
    phase_t     phase_reg;
    logic       protect_reg;
    logic       brace_reg;

    step_t      step;
    logic       fifo_room;
    logic       advance;
    result_t    out_res;
    logic [1:0] push_n;

    // the registered beat is parsed once the queue can take its results
    assign advance = in_valid_reg && fifo_room;
    assign s_ready = !in_valid_reg || advance;
    assign push_n  = advance ? step.count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_is_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LINE;
            protect_reg <= 1'b0;
            brace_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg   <= step.phase_next;
            protect_reg <= step.protect_next;
            brace_reg   <= step.brace_next;
        end
    end

    tlp_step u_step (
        .phase     (phase_reg),
        .protect   (protect_reg),
        .brace     (brace_reg),
        .data_byte (in_byte_reg),
        .is_end    (in_end_reg),
        .step      (step)
    );

    tlp_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (step.res0),
        .push1     (step.res1),
        .room      (fifo_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_kind     = out_res.kind;
    assign m_out_byte = out_res.out_byte;
    assign m_status   = out_res.status;
    assign m_last     = out_res.last;

    // error phase is left only by reset
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ERR |=> phase_reg == PH_ERR)
        else $error("parser left error phase without reset");

    // an accepted beat always lands in the input register
    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted input beat was dropped");

    // only record beats carry a status
    a_status_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_REC |-> m_status == ST_NONE)
        else $error("status set on a non-record beat");

    // protect flag lives only inside a line
    a_protect_line: assert property (@(posedge aclk) disable iff (!aresetn)
        protect_reg |-> phase_reg != PH_LINE && phase_reg != PH_ERR)
        else $error("protect flag outside a line");

endmodule
